@@ design/iirbq_pkg.sv @@
`default_nettype none
package iirbq_pkg;

  localparam int SampleW     = 16;
  localparam int CoefW       = 24;
  localparam int StateW      = 40;
  localparam int CoefFrac    = CoefW - 4;
  localparam int StateFrac   = StateW - 10;
  localparam int SampleShift = StateFrac - 15;
  localparam int NumStages   = 2;
  localparam int NumRegs     = 3 * NumStages;
  localparam int CfgIdxW     = 3;
  localparam int AccW        = CoefW + StateW;
  // A rounded product keeps the integer part of the full product.
  localparam int ProdW       = AccW - CoefFrac;
  // Room for 2*p - q1 + sd before saturation.
  localparam int SumW        = ProdW + 4;
  localparam int CntW        = $clog2(CoefW + 1);

  // Register roles inside one stage.
  localparam logic [1:0] RoleGain = 2'd0;
  localparam logic [1:0] RoleA1   = 2'd1;
  localparam logic [1:0] RoleA2   = 2'd2;

  // Clamp a wide signed sum to the signed state range.
  function automatic logic signed [StateW-1:0] sat_state(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = (SumW'(1) <<< (StateW - 1)) - SumW'(1);
    lo = -hi - SumW'(1);
    if (v > hi) begin
      sat_state = hi[StateW-1:0];
    end else if (v < lo) begin
      sat_state = lo[StateW-1:0];
    end else begin
      sat_state = v[StateW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ design/iir_biquad_cascade_lowpass_core.sv @@
`default_nettype none
// Fourth-order lowpass made of two cascaded transposed direct-form-II biquads.
// Input channel (in_valid_i/in_ready_o) moves one word: a Q1.15 sample and a
// channel-select flag. A word with the flag low is consumed without a result
// and leaves the filter state alone. A word with the flag high produces one
// output word (out_valid_o/out_ready_i) carrying the saturated Q1.15 result.
// Coefficients are written through the configuration channel (index 0..5:
// stage0 gain, a1, a2, stage1 gain, a1, a2); other indexes are ignored.
// All six products go through one shift-add multiplier that retires one
// coefficient bit per cycle. Each of the six multiplies runs through operand
// load, 24 bit steps, rounding and state update. An ignored word is consumed
// while the sequencer stays idle. The next word is taken as soon as the
// sequencer is idle, even while the previous result still waits in the
// output register. If the receiver stalls, the sequencer holds its final
// result until that register frees up. Reset clears the coefficients, the
// delay states and all handshake state.
module iir_biquad_cascade_lowpass_core
  import iirbq_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [SampleW-1:0] sample_in_i,
  input  wire logic                      channel_selected_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [SampleW-1:0]      sample_out_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [CoefW-1:0]          cfg_data_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoad  = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StApply = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]               state_q;
  logic [1:0]               role_q;
  logic                     stage_q;
  logic [CntW-1:0]          cnt_q;
  logic signed [CoefW-1:0]  coef_q [NumRegs];
  logic signed [StateW-1:0] fd_q [NumStages];
  logic signed [StateW-1:0] sd_q [NumStages];
  logic signed [StateW-1:0] y_q;
  logic signed [ProdW-1:0]  p_q;
  logic signed [ProdW-1:0]  q1_q;
  logic signed [ProdW-1:0]  prod_q;
  logic [AccW-1:0]          acc_q;
  logic [CoefW-1:0]         mc_q;
  logic [StateW-1:0]        ms_q;
  logic                     neg_q;
  logic                     out_valid_q;
  logic signed [SampleW-1:0] out_q;

  logic signed [CoefW-1:0]  coef_sel;
  logic [2:0]               coef_idx;
  logic [StateW:0]          mul_sum;
  logic [AccW-1:0]          rnd_sum;
  logic [ProdW-1:0]         rnd_mag;
  logic signed [SumW-1:0]   prod_w, p_w, q1_w, fd_w, sd_w;
  logic [StateW-1:0]        y_mag;
  logic [StateW-SampleShift-1:0] y_shr;
  logic signed [SampleW-1:0] out_conv;
  logic                     out_load;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // The output register takes a new word when it is empty or being drained.
  assign out_load = (state_q == StOut) && (!out_valid_q || out_ready_i);

  assign coef_idx = 3'(stage_q) * 3'd3 + 3'(role_q);
  assign coef_sel = coef_q[coef_idx];

  // Shift-add step: add the value magnitude into the upper half, shift right.
  assign mul_sum = {1'b0, acc_q[AccW-1:CoefW]} + (mc_q[0] ? {1'b0, ms_q} : '0);

  // Round to nearest, ties away from zero, on the magnitude.
  assign rnd_sum = acc_q + (AccW'(1) << (CoefFrac - 1));
  assign rnd_mag = rnd_sum[AccW-1:CoefFrac];

  assign prod_w = SumW'(prod_q);
  assign p_w    = SumW'(p_q);
  assign q1_w   = SumW'(q1_q);
  assign fd_w   = SumW'(fd_q[stage_q]);
  assign sd_w   = SumW'(sd_q[stage_q]);

  // Output conversion truncates toward zero, then clamps to 16 bits.
  always_comb begin
    y_mag = y_q[StateW-1] ? StateW'(-y_q) : StateW'(y_q);
    y_shr = y_mag[StateW-1:SampleShift];
    if (y_q[StateW-1]) begin
      if (y_shr > (StateW-SampleShift)'(32768)) begin
        out_conv = SampleW'(-32768);
      end else begin
        out_conv = SampleW'(-$signed({1'b0, y_shr}));
      end
    end else if (y_shr > (StateW-SampleShift)'(32767)) begin
      out_conv = SampleW'(32767);
    end else begin
      out_conv = SampleW'(y_shr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      role_q      <= RoleGain;
      stage_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumRegs; i++) begin
        coef_q[i] <= '0;
      end
      for (int i = 0; i < NumStages; i++) begin
        fd_q[i] <= '0;
        sd_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumRegs))) begin
        coef_q[cfg_index_i] <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && channel_selected_i) begin
            y_q     <= StateW'(sample_in_i) <<< SampleShift;
            role_q  <= RoleGain;
            stage_q <= 1'b0;
            state_q <= StLoad;
          end
        end
        StLoad: begin
          mc_q    <= coef_sel[CoefW-1] ? CoefW'(-coef_sel) : CoefW'(coef_sel);
          ms_q    <= y_q[StateW-1] ? StateW'(-y_q) : StateW'(y_q);
          neg_q   <= coef_sel[CoefW-1] ^ y_q[StateW-1];
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= StMul;
        end
        StMul: begin
          acc_q <= {mul_sum, acc_q[CoefW-1:1]};
          mc_q  <= mc_q >> 1;
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(CoefW - 1)) begin
            state_q <= StRound;
          end
        end
        StRound: begin
          prod_q  <= neg_q ? -$signed(rnd_mag) : $signed(rnd_mag);
          state_q <= StApply;
        end
        StApply: begin
          state_q <= StLoad;
          unique case (role_q)
            RoleGain: begin
              p_q    <= prod_q;
              y_q    <= sat_state(prod_w + fd_w);
              role_q <= RoleA1;
            end
            RoleA1: begin
              q1_q   <= prod_q;
              role_q <= RoleA2;
            end
            RoleA2: begin
              fd_q[stage_q] <= sat_state((p_w <<< 1) - q1_w + sd_w);
              sd_q[stage_q] <= sat_state(p_w - prod_w);
              role_q        <= RoleGain;
              if (stage_q == 1'(NumStages - 1)) begin
                state_q <= StOut;
              end else begin
                stage_q <= stage_q + 1'b1;
              end
            end
            default: begin
              role_q <= RoleGain;
            end
          endcase
        end
        StOut: begin
          if (out_load) begin
            out_q   <= out_conv;
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // The bit counter never runs past the coefficient width.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |-> (cnt_q < CntW'(CoefW)))
    else $error("multiplier step counter overran");

  // A result is only posted after the last state update of the last stage.
  a_out_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StOut) && ($past(state_q) != StOut)) |->
      ($past(state_q) == StApply && $past(role_q) == RoleA2))
    else $error("output posted before the cascade finished");

  // A word is never taken while the sequencer is busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |=> !in_ready_o)
    else $error("input taken while multiplying");

endmodule
`default_nettype wire
